// ----- rtl/reciprocal_frequency_compute_macros.svh -----
// Assertion helpers shared by the checker file.
`ifndef RECIPROCAL_FREQUENCY_COMPUTE_MACROS_SVH
`define RECIPROCAL_FREQUENCY_COMPUTE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rfc_pkg.sv -----
package rfc_pkg;

   localparam int DEFAULT_CHANNEL_COUNT = 2;
   localparam int DEFAULT_COUNT_WIDTH   = 32;
   localparam int DEFAULT_FRACTION_BITS = 16;

   localparam int FIELD_W    = 32;
   localparam int REF_HZ_W   = 28;
   localparam int MIN_BASE_W = 32;
   localparam int LIMIT_W    = 4;
   localparam int FREQ_W     = 48;
   localparam int OUTCOME_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   localparam logic [OUTCOME_W-1:0] OUTCOME_NEW     = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_RETRY   = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_GAVE_UP = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_REFERENCE_CLOCK_HZ = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MINIMUM_BASE_COUNT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ATTEMPT_LIMIT      = 2'd2;

   localparam logic [REF_HZ_W-1:0]   REF_HZ_RESET   = 28'd150000000;
   localparam logic [MIN_BASE_W-1:0] MIN_BASE_RESET = 32'd14000000;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 4'd10;

   typedef struct packed {
      logic               channel;
      logic [FIELD_W-1:0] signal_count;
      logic [FIELD_W-1:0] base_count;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0]    frequency;
      logic [FIELD_W-1:0]   reported_signal_count;
      logic [FIELD_W-1:0]   reported_base_count;
      logic [OUTCOME_W-1:0] outcome;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] frequency;
   } div_status_type;

endpackage

// ----- rtl/reciprocal_frequency_compute.sv -----
// Reciprocal frequency computation for a small set of measurement channels.
// req channel (valid/ready): one gated attempt per transaction, carrying the
//   channel, the signal-edge count and the reference-clock count of the gate.
// rsp channel (valid/ready): exactly one result per attempt, in order:
//   outcome new (frequency in Hz, FRACTION_BITS fraction bits, saturated),
//   retry (frequency 0, counts of the failed attempt) or gave up (held values).
// APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): reference clock
//   in Hz at 0x0, minimum base count at 0x4, attempt limit at 0x8.
// A valid attempt goes from acceptance through a multiply step, then the
//   bit-serial restoring divider produces one quotient bit per cycle. An
//   invalid attempt skips both and goes straight to the finish state. One
//   attempt is in flight at a time; req_ready is low from acceptance until
//   the result moves into the output register.
// The output register lets the next attempt start while a result is stalled;
//   a finished second result waits until the first one is taken.
// Reset (synchronous) restores the register defaults and clears the held
//   values and attempt counters of all channels.
module reciprocal_frequency_compute import rfc_pkg::*; #(
   parameter int CHANNEL_COUNT = DEFAULT_CHANNEL_COUNT,
   parameter int COUNT_WIDTH   = DEFAULT_COUNT_WIDTH,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   typedef enum logic [1:0] {T_IDLE, T_COMPUTE, T_FINISH} top_state_type;

   // configuration
   logic [REF_HZ_W-1:0]   ref_hz_ff;
   logic [MIN_BASE_W-1:0] min_base_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic                  csr_write;
   logic [REG_IDX_W-1:0]  reg_idx;

   // per-channel state
   logic [FREQ_W-1:0]      held_freq_ff [CHANNEL_COUNT];
   logic [COUNT_WIDTH-1:0] held_sig_ff  [CHANNEL_COUNT];
   logic [COUNT_WIDTH-1:0] held_base_ff [CHANNEL_COUNT];
   logic [LIMIT_W-1:0]     attempt_ff   [CHANNEL_COUNT];

   top_state_type  state_ff, state_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   rsp_type        pend_ff, pend_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [COUNT_WIDTH-1:0] sig_cut, base_cut;
   logic [CH_W-1:0]        req_ch, attempt_ch;
   logic                   attempt_ok, retry_ok;
   logic                   div_start;
   div_status_type         div_status;
   logic                   attempt_we, held_we;
   logic [LIMIT_W-1:0]     attempt_wdata;

   assign sig_cut  = req_payload.signal_count[COUNT_WIDTH-1:0];
   assign base_cut = req_payload.base_count[COUNT_WIDTH-1:0];
   assign req_ch   = (CHANNEL_COUNT == 1) ? '0 : CH_W'(req_payload.channel);

   assign attempt_ok = (sig_cut != '0) && (MIN_BASE_W'(base_cut) > min_base_ff);
   assign retry_ok   = ({1'b0, attempt_ff[req_ch]} + 1'b1) < {1'b0, limit_ff};

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      div_start     = 1'b0;
      attempt_we    = 1'b0;
      attempt_wdata = '0;
      attempt_ch    = ch_ff;
      held_we       = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            attempt_ch = req_ch;
            if (req_valid) begin
               ch_in                         = req_ch;
               pend_in.reported_signal_count = FIELD_W'(sig_cut);
               pend_in.reported_base_count   = FIELD_W'(base_cut);
               pend_in.frequency             = '0;
               if (attempt_ok) begin
                  div_start       = 1'b1;
                  pend_in.outcome = OUTCOME_NEW;
                  state_in        = T_COMPUTE;
               end else if (retry_ok) begin
                  pend_in.outcome = OUTCOME_RETRY;
                  attempt_we      = 1'b1;
                  attempt_wdata   = attempt_ff[req_ch] + 1'b1;
                  state_in        = T_FINISH;
               end else begin
                  pend_in.frequency             = held_freq_ff[req_ch];
                  pend_in.reported_signal_count = FIELD_W'(held_sig_ff[req_ch]);
                  pend_in.reported_base_count   = FIELD_W'(held_base_ff[req_ch]);
                  pend_in.outcome               = OUTCOME_GAVE_UP;
                  attempt_we                    = 1'b1;
                  state_in                      = T_FINISH;
               end
            end
         end
         T_COMPUTE: begin
            if (div_status.done) begin
               pend_in.frequency = div_status.frequency;
               held_we           = 1'b1;
               attempt_we        = 1'b1;
               state_in          = T_FINISH;
            end
         end
         T_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff   <= ch_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            held_freq_ff[i] <= '0;
            held_sig_ff[i]  <= '0;
            held_base_ff[i] <= '0;
            attempt_ff[i]   <= '0;
         end
      end else begin
         if (attempt_we) begin
            attempt_ff[attempt_ch] <= attempt_wdata;
         end
         if (held_we) begin
            held_freq_ff[ch_ff] <= div_status.frequency;
            held_sig_ff[ch_ff]  <= pend_ff.reported_signal_count[COUNT_WIDTH-1:0];
            held_base_ff[ch_ff] <= pend_ff.reported_base_count[COUNT_WIDTH-1:0];
         end
      end
   end

   rfc_divider #(
      .COUNT_WIDTH   (COUNT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .signal_count (sig_cut),
      .reference_hz (ref_hz_ff),
      .base_count   (base_cut),
      .status       (div_status)
   );

   // register file
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_hz_ff   <= REF_HZ_RESET;
         min_base_ff <= MIN_BASE_RESET;
         limit_ff    <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_REFERENCE_CLOCK_HZ: ref_hz_ff   <= pwdata[REF_HZ_W-1:0];
            REG_MINIMUM_BASE_COUNT: min_base_ff <= pwdata[MIN_BASE_W-1:0];
            REG_ATTEMPT_LIMIT:      limit_ff    <= pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_REFERENCE_CLOCK_HZ: prdata = CSR_DATA_W'(ref_hz_ff);
         REG_MINIMUM_BASE_COUNT: prdata = CSR_DATA_W'(min_base_ff);
         REG_ATTEMPT_LIMIT:      prdata = CSR_DATA_W'(limit_ff);
         default:                prdata = '0;
      endcase
   end

   assign pready      = 1'b1;
   assign req_ready   = (state_ff == T_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/rfc_divider.sv -----
module rfc_divider import rfc_pkg::*; #(
   parameter int COUNT_WIDTH   = DEFAULT_COUNT_WIDTH,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [COUNT_WIDTH-1:0] signal_count,
   input  logic [REF_HZ_W-1:0]    reference_hz,
   input  logic [COUNT_WIDTH-1:0] base_count,
   output div_status_type         status
);

   localparam int PROD_W    = COUNT_WIDTH + REF_HZ_W;
   localparam int DIV_STEPS = PROD_W + FRACTION_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {D_IDLE, D_MULT, D_SHIFT, D_DONE} div_state_type;

   div_state_type          state_ff, state_in;
   logic [COUNT_WIDTH-1:0] sig_ff, sig_in;
   logic [REF_HZ_W-1:0]    ref_ff, ref_in;
   logic [COUNT_WIDTH-1:0] base_ff, base_in;
   logic [PROD_W-1:0]      dividend_ff, dividend_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0]      quo_ff, quo_in;
   logic                   sat_ff, sat_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   logic [PROD_W-1:0]        product;
   logic [COUNT_WIDTH:0]     partial;
   logic [COUNT_WIDTH+1:0]   diff;
   logic                     q_bit;

   // one restoring-division step: remainder stays below the divisor
   assign product = sig_ff * ref_ff;
   assign partial = {rem_ff, dividend_ff[PROD_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, base_ff};
   assign q_bit   = ~diff[COUNT_WIDTH+1];

   always_comb begin
      state_in    = state_ff;
      sig_in      = sig_ff;
      ref_in      = ref_ff;
      base_in     = base_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      sat_in      = sat_ff;
      step_in     = step_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               sig_in   = signal_count;
               ref_in   = reference_hz;
               base_in  = base_count;
               state_in = D_MULT;
            end
         end
         D_MULT: begin
            dividend_in = product;
            rem_in      = '0;
            quo_in      = '0;
            sat_in      = 1'b0;
            step_in     = '0;
            state_in    = D_SHIFT;
         end
         D_SHIFT: begin
            rem_in      = q_bit ? diff[COUNT_WIDTH-1:0] : partial[COUNT_WIDTH-1:0];
            // a quotient bit pushed past the top means the result saturates
            sat_in      = sat_ff | quo_ff[FREQ_W-1];
            quo_in      = {quo_ff[FREQ_W-2:0], q_bit};
            dividend_in = {dividend_ff[PROD_W-2:0], 1'b0};
            step_in     = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sig_ff      <= sig_in;
      ref_ff      <= ref_in;
      base_ff     <= base_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sat_ff      <= sat_in;
      step_ff     <= step_in;
   end

   assign status.done      = (state_ff == D_DONE);
   assign status.frequency = sat_ff ? FREQ_MAX : quo_ff;

endmodule

// ----- rtl/rfc_checker.sv -----
`include "reciprocal_frequency_compute_macros.svh"

module rfc_checker import rfc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic rsp_stall;
   logic req_take;
   logic retry_out;
   logic new_out;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign retry_out = rsp_valid && (rsp_payload.outcome == OUTCOME_RETRY);
   assign new_out   = rsp_valid && (rsp_payload.outcome == OUTCOME_NEW);

   // a stalled result must not move
   `RFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // one attempt at a time: no back-to-back acceptance
   `RFC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_take, !req_ready,
      "input accepted while busy")

   // a retry never reports a frequency
   `RFC_ASSERT_SAME(a_retry_zero, clock, reset, retry_out, rsp_payload.frequency == '0,
      "retry with nonzero frequency")

   // a new measurement comes only from nonzero counts
   `RFC_ASSERT_SAME(a_new_counts, clock, reset, new_out,
      (rsp_payload.reported_signal_count != '0) && (rsp_payload.reported_base_count != '0),
      "new measurement with zero count")

endmodule

bind reciprocal_frequency_compute rfc_checker u_rfc_checker (.*);
